FILE: hw/rtl/trc_pkg.sv
// Shared types, constants and codes for the TCP reply classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package trc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16383;
    localparam int FIFO_DEPTH          = 3;
    localparam int NUM_COUNTED         = 8;

    localparam logic [39:0] EVT_INTERVAL_RST = 40'd200000000;

    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [7:0]  IHL_MASK      = 8'h0f;
    localparam logic [3:0]  IHL_MIN       = 4'd5;

    localparam int TCP_FIN = 0;
    localparam int TCP_SYN = 1;
    localparam int TCP_RST = 2;
    localparam int TCP_ACK = 4;

    localparam logic [3:0] CLS_MALFORMED = 4'd0;
    localparam logic [3:0] CLS_NONIP     = 4'd1;
    localparam logic [3:0] CLS_UDP       = 4'd2;
    localparam logic [3:0] CLS_OTHERIP   = 4'd3;
    localparam logic [3:0] CLS_RST       = 4'd4;
    localparam logic [3:0] CLS_SYNACK    = 4'd5;
    localparam logic [3:0] CLS_SYN       = 4'd6;
    localparam logic [3:0] CLS_FIN       = 4'd7;
    localparam logic [3:0] CLS_ACK       = 4'd8;
    localparam logic [3:0] CLS_ODDFLAGS  = 4'd9;

    localparam logic EVT_KIND_RST = 1'b0;
    localparam logic EVT_KIND_ODD = 1'b1;

    localparam logic REG_EVENT_INTERVAL = 1'b0;
    localparam logic REG_PORT_NUMBER    = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [63:0] timestamp_ns;
    } trc_in_t;

    typedef struct packed {
        logic [3:0]  pkt_class;
        logic [63:0] class_count;
        logic [63:0] total_packets;
        logic [63:0] total_bytes;
        logic        event_valid;
        logic        event_kind;
        logic [63:0] event_time;
        logic [31:0] event_src_addr;
        logic [31:0] event_dst_addr;
        logic [15:0] event_src_port;
        logic [15:0] event_dst_port;
        logic [15:0] event_port;
    } trc_out_t;

    typedef struct packed {
        logic [15:0] outer_type;
        logic [15:0] inner_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
    } trc_hdr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trc_parser.sv
// Byte-stream frame parser: tracks the byte offset and captures header fields.
// Depends on trc_pkg; feeds trc_classifier with the header and a frame-done item.
`default_nettype none

module trc_parser #(
    parameter int MAX_FRAME_BYTES = trc_pkg::MAX_FRAME_BYTES_DEF,
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire trc_pkg::trc_in_t   item,
    output trc_pkg::trc_hdr_t       hdr,
    output logic                    frame_done,
    output logic [LEN_W-1:0]        frame_len,
    output logic [63:0]             frame_time
);
    import trc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] OFS_OTYPE_H = LEN_W'(12);
    localparam logic [LEN_W-1:0] OFS_OTYPE_L = LEN_W'(13);
    localparam logic [LEN_W-1:0] OFS_ITYPE_H = LEN_W'(16);
    localparam logic [LEN_W-1:0] OFS_ITYPE_L = LEN_W'(17);
    localparam logic [LEN_W-1:0] ETH_HDR     = LEN_W'(14);
    localparam logic [LEN_W-1:0] VLAN_HDR    = LEN_W'(18);
    localparam logic [LEN_W-1:0] IP_MIN      = LEN_W'(20);

    logic [LEN_W-1:0] offset_reg;
    logic [LEN_W-1:0] offset_next;
    trc_hdr_t         hdr_reg;
    trc_hdr_t         hdr_next;
    logic             done_reg;
    logic [LEN_W-1:0] len_reg;
    logic [63:0]      time_reg;

    logic [LEN_W-1:0] idx;
    logic [LEN_W:0]   idx_p1;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] rel;
    logic [LEN_W-1:0] hl;
    logic [LEN_W-1:0] r4;
    logic [7:0]       b;

    always_comb
    begin
        idx    = item.first_byte ? '0 : offset_reg;
        idx_p1 = {1'b0, idx} + (LEN_W+1)'(1);
        len    = (idx_p1 > {1'b0, MAX_LEN}) ? MAX_LEN : idx_p1[LEN_W-1:0];
        b      = item.data_byte;
        base   = (hdr_reg.outer_type == ETH_TYPE_VLAN) ? VLAN_HDR : ETH_HDR;
        rel    = idx - base;
        hl     = LEN_W'({hdr_reg.header_words, 2'b00});
        r4     = rel - hl;

        offset_next = item.last_byte ? '0 : len;
        hdr_next    = hdr_reg;

        if (idx < MAX_LEN)
        begin
            if (idx == OFS_OTYPE_H) hdr_next.outer_type[15:8] = b;
            if (idx == OFS_OTYPE_L) hdr_next.outer_type[7:0]  = b;
            if (idx == OFS_ITYPE_H) hdr_next.inner_type[15:8] = b;
            if (idx == OFS_ITYPE_L) hdr_next.inner_type[7:0]  = b;

            if (idx >= ETH_HDR && idx >= base)
            begin
                if (rel == LEN_W'(0))
                    hdr_next.header_words = 4'(b & IHL_MASK);
                else if (rel == LEN_W'(9))
                    hdr_next.ip_protocol = b;
                else if (rel >= LEN_W'(12) && rel < LEN_W'(16))
                    hdr_next.source_address = {hdr_reg.source_address[23:0], b};
                else if (rel >= LEN_W'(16) && rel < IP_MIN)
                    hdr_next.dest_address = {hdr_reg.dest_address[23:0], b};

                if (rel >= IP_MIN && rel >= hl)
                begin
                    if (r4 == LEN_W'(0))
                        hdr_next.source_port[15:8] = b;
                    else if (r4 == LEN_W'(1))
                        hdr_next.source_port[7:0] = b;
                    else if (r4 == LEN_W'(2))
                        hdr_next.dest_port[15:8] = b;
                    else if (r4 == LEN_W'(3))
                        hdr_next.dest_port[7:0] = b;
                    else if (r4 == LEN_W'(13))
                        hdr_next.tcp_flag_bits = b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            hdr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= accept && item.last_byte;
            if (accept)
            begin
                offset_reg <= offset_next;
                hdr_reg    <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg  <= len;
            time_reg <= item.timestamp_ns;
        end
    end

    assign hdr        = hdr_reg;
    assign frame_done = done_reg;
    assign frame_len  = len_reg;
    assign frame_time = time_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/trc_classifier.sv
// Frame classifier: class decision, saturating counters and event rate limiters.
// Depends on trc_pkg; takes trc_parser output and produces one result per frame.
`default_nettype none

module trc_classifier #(
    parameter int MAX_FRAME_BYTES = trc_pkg::MAX_FRAME_BYTES_DEF,
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trc_pkg::trc_hdr_t  hdr,
    input  wire logic               frame_done,
    input  wire logic [LEN_W-1:0]   frame_len,
    input  wire logic [63:0]        frame_time,
    input  wire logic [39:0]        event_interval_ns,
    input  wire logic [15:0]        port_number,
    output trc_pkg::trc_out_t       result
);
    import trc_pkg::*;

    localparam int SLOT_W = $clog2(NUM_COUNTED);

    logic [63:0] pkt_total_reg;
    logic [63:0] pkt_total_next;
    logic [63:0] byte_total_reg;
    logic [63:0] byte_total_next;
    logic [63:0] class_cnt_reg [NUM_COUNTED];
    logic [63:0] class_cnt_next;
    logic [63:0] last_evt_reg [2];

    logic             vlan;
    logic [15:0]      etype;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] ip_need;
    logic [LEN_W-1:0] tcp_need;
    logic [3:0]       cls;
    logic             evt_req;
    logic             evt_kind;
    logic             counted;
    logic [SLOT_W-1:0] slot;
    logic [64:0]      byte_sum;
    logic [63:0]      evt_diff;
    logic             evt_pass;

    always_comb
    begin
        vlan     = (hdr.outer_type == ETH_TYPE_VLAN);
        etype    = vlan ? hdr.inner_type : hdr.outer_type;
        base     = vlan ? LEN_W'(18) : LEN_W'(14);
        ip_need  = base + LEN_W'(20);
        tcp_need = base + LEN_W'({hdr.header_words, 2'b00}) + LEN_W'(20);
        cls      = CLS_MALFORMED;
        evt_req  = 1'b0;
        evt_kind = EVT_KIND_RST;

        if (frame_len < LEN_W'(14))
            cls = CLS_MALFORMED;
        else if (vlan && frame_len < LEN_W'(18))
            cls = CLS_MALFORMED;
        else if (etype != ETH_TYPE_IPV4)
            cls = CLS_NONIP;
        else if (frame_len < ip_need)
            cls = CLS_MALFORMED;
        else if (hdr.header_words < IHL_MIN)
            cls = CLS_MALFORMED;
        else if (hdr.ip_protocol == IP_PROTO_UDP)
            cls = CLS_UDP;
        else if (hdr.ip_protocol != IP_PROTO_TCP)
            cls = CLS_OTHERIP;
        else if (frame_len < tcp_need)
            cls = CLS_MALFORMED;
        else if (hdr.tcp_flag_bits[TCP_RST])
        begin
            cls     = CLS_RST;
            evt_req = 1'b1;
        end
        else if (hdr.tcp_flag_bits[TCP_SYN] && hdr.tcp_flag_bits[TCP_ACK])
            cls = CLS_SYNACK;
        else if (hdr.tcp_flag_bits[TCP_SYN])
            cls = CLS_SYN;
        else if (hdr.tcp_flag_bits[TCP_FIN])
            cls = CLS_FIN;
        else if (hdr.tcp_flag_bits[TCP_ACK])
            cls = CLS_ACK;
        else
        begin
            cls      = CLS_ODDFLAGS;
            evt_req  = 1'b1;
            evt_kind = EVT_KIND_ODD;
        end
    end

    always_comb
    begin
        counted = 1'b1;
        case (cls)
            CLS_NONIP:    slot = SLOT_W'(0);
            CLS_UDP:      slot = SLOT_W'(1);
            CLS_RST:      slot = SLOT_W'(2);
            CLS_SYNACK:   slot = SLOT_W'(3);
            CLS_SYN:      slot = SLOT_W'(4);
            CLS_FIN:      slot = SLOT_W'(5);
            CLS_ACK:      slot = SLOT_W'(6);
            CLS_ODDFLAGS: slot = SLOT_W'(7);
            default:
            begin
                slot    = '0;
                counted = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        class_cnt_next  = (&class_cnt_reg[slot]) ? class_cnt_reg[slot]
                                                 : class_cnt_reg[slot] + 64'd1;
        pkt_total_next  = (&pkt_total_reg) ? pkt_total_reg : pkt_total_reg + 64'd1;
        byte_sum        = {1'b0, byte_total_reg} + 65'(frame_len);
        byte_total_next = byte_sum[64] ? {64{1'b1}} : byte_sum[63:0];
        evt_diff        = frame_time - last_evt_reg[evt_kind];
        evt_pass        = evt_req && (evt_diff >= {24'b0, event_interval_ns});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_total_reg  <= '0;
            byte_total_reg <= '0;
            for (int i = 0; i < NUM_COUNTED; i++)
            begin
                class_cnt_reg[i] <= '0;
            end
            last_evt_reg[0] <= '0;
            last_evt_reg[1] <= '0;
        end
        else if (frame_done)
        begin
            pkt_total_reg  <= pkt_total_next;
            byte_total_reg <= byte_total_next;
            if (counted)
                class_cnt_reg[slot] <= class_cnt_next;
            if (evt_pass)
                last_evt_reg[evt_kind] <= frame_time;
        end
    end

    always_comb
    begin
        result               = '0;
        result.pkt_class     = cls;
        result.class_count   = counted ? class_cnt_next : '0;
        result.total_packets = pkt_total_next;
        result.total_bytes   = byte_total_next;
        if (evt_pass)
        begin
            result.event_valid    = 1'b1;
            result.event_kind     = evt_kind;
            result.event_time     = frame_time;
            result.event_src_addr = hdr.source_address;
            result.event_dst_addr = hdr.dest_address;
            result.event_src_port = hdr.source_port;
            result.event_dst_port = hdr.dest_port;
            result.event_port     = port_number;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/trc_result_fifo.sv
// Small result queue that decouples classification from the output handshake.
// Depends on trc_pkg for the result type and queue depth.
`default_nettype none

module trc_result_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire trc_pkg::trc_out_t  push_item,
    input  wire logic               pop,
    output logic                    valid,
    output trc_pkg::trc_out_t       item,
    output logic [$clog2(trc_pkg::FIFO_DEPTH+1)-1:0] count
);
    import trc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    trc_out_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    assign valid = (count_reg != '0);
    assign item  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcp_reply_classifier_top.sv
// Top level of the TCP reply classifier: APB registers, parser, classifier, queue.
// Depends on trc_pkg, trc_parser, trc_classifier and trc_result_fifo.
// The parser registers a frame's end and the queue then stores its result, making it visible.
// Throughput: one byte per cycle, one-byte frames included, while results drain.
// Backpressure: bytes stall once queued plus in-flight results reach the queue depth of three.
// Reset: rst_n clears offsets, captured headers, all counters and event times.
`default_nettype none

module tcp_reply_classifier_top #(
    parameter int MAX_FRAME_BYTES = trc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire trc_pkg::trc_in_t   byte_item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output trc_pkg::trc_out_t       result_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    import trc_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [39:0]      interval_reg;
    logic [15:0]      port_reg;
    logic             cfg_write;
    logic             byte_accept;
    trc_hdr_t         hdr;
    logic             frame_done;
    logic [LEN_W-1:0] frame_len;
    logic [63:0]      frame_time;
    trc_out_t         cls_result;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W:0]   pending;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= EVT_INTERVAL_RST;
            port_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3])
                REG_EVENT_INTERVAL: interval_reg <= pwdata[39:0];
                REG_PORT_NUMBER:    port_reg     <= pwdata[15:0];
                default:            port_reg     <= port_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_EVENT_INTERVAL: prdata = {24'b0, interval_reg};
            REG_PORT_NUMBER:    prdata = {48'b0, port_reg};
            default:            prdata = '0;
        endcase
    end

    assign pending     = {1'b0, fifo_count} + (CNT_W+1)'(frame_done);
    assign byte_ready  = (pending < (CNT_W+1)'(FIFO_DEPTH));
    assign byte_accept = byte_valid && byte_ready;

    trc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (byte_accept),
        .item       (byte_item),
        .hdr        (hdr),
        .frame_done (frame_done),
        .frame_len  (frame_len),
        .frame_time (frame_time)
    );

    trc_classifier #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_classifier (
        .clk               (clk),
        .rst_n             (rst_n),
        .hdr               (hdr),
        .frame_done        (frame_done),
        .frame_len         (frame_len),
        .frame_time        (frame_time),
        .event_interval_ns (interval_reg),
        .port_number       (port_reg),
        .result            (cls_result)
    );

    trc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_done),
        .push_item (cls_result),
        .pop       (result_valid && result_ready),
        .valid     (result_valid),
        .item      (result_item),
        .count     (fifo_count)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> (fifo_count < CNT_W'(FIFO_DEPTH)) ||
                       (result_valid && result_ready))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && byte_item.last_byte) |=> frame_done)
        else $error("last byte did not produce a frame result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.event_valid) |->
            (result_item.pkt_class == CLS_RST || result_item.pkt_class == CLS_ODDFLAGS))
        else $error("event raised for a class without events");

    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && !byte_item.last_byte) |=> !frame_done)
        else $error("frame result without a last byte");

endmodule

`default_nettype wire

FILE: tb/tcp_reply_classifier_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_reply_classifier_top: frames go in byte by byte and
// every classification result is checked against a cycle-free model of the parser and classifier.
// Depends on trc_pkg and the classifier RTL; needs no files or arguments.

module tcp_reply_classifier_top_tb;
    import trc_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RANDOM_BYTES    = 800;
    localparam int CALM_BYTES      = 120;
    localparam int SETTLE_CYCLES   = 6;

    typedef struct {
        bit        vlan;
        bit [15:0] etype;
        bit [3:0]  ihl;
        bit [7:0]  proto;
        bit [7:0]  flags;
        int        len;
        bit        abort;
        bit        nofirst;
        bit [63:0] ts_step;
        bit        typed;
        bit [3:0]  cls;
    } frame_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    trc_in_t     byte_item    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    trc_out_t    result_item;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;
    logic [63:0] prdata;
    logic        pready;

    tcp_reply_classifier_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // parser and classifier model state
    bit [13:0] fr_offset;
    bit [15:0] eth_outer;
    bit [15:0] eth_inner;
    bit [3:0]  ihl_words;
    bit [7:0]  proto_num;
    bit [31:0] ip_src;
    bit [31:0] ip_dst;
    bit [15:0] tcp_sport;
    bit [15:0] tcp_dport;
    bit [7:0]  seg_flags;
    bit [63:0] pkt_total;
    bit [63:0] byte_sum;
    bit [63:0] class_tally [NUM_COUNTED];
    bit [63:0] last_evt_ts [2];
    bit [39:0] cfg_interval = EVT_INTERVAL_RST;
    bit [15:0] cfg_port;

    trc_out_t  results_due [$];
    bit [63:0] clock_ns;
    bit        calm;
    bit        tx_idle;
    int        rx_hold;
    int        stall_cycles;
    int        bytes_sent;
    int        frames_sent;
    int        results_made;
    int        results_seen;
    int        events_due;
    int        mismatches;

    function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
        bit [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic void grab_byte(int idx, bit [7:0] b);
        int base;
        int rel;
        int hl;
        if (idx == 12) eth_outer[15:8] = b;
        else if (idx == 13) eth_outer[7:0] = b;
        else if (idx == 16) eth_inner[15:8] = b;
        else if (idx == 17) eth_inner[7:0] = b;
        if (idx < 14) return;
        base = (eth_outer == ETH_TYPE_VLAN) ? 18 : 14;
        if (idx < base) return;
        rel = idx - base;
        if (rel == 0) ihl_words = 4'(b & IHL_MASK);
        else if (rel == 9) proto_num = b;
        else if (rel >= 12 && rel < 16) ip_src = {ip_src[23:0], b};
        else if (rel >= 16 && rel < 20) ip_dst = {ip_dst[23:0], b};
        if (rel < 20) return;
        hl = 4 * int'(ihl_words);
        if (rel < hl) return;
        case (rel - hl)
            0:  tcp_sport[15:8] = b;
            1:  tcp_sport[7:0]  = b;
            2:  tcp_dport[15:8] = b;
            3:  tcp_dport[7:0]  = b;
            13: seg_flags       = b;
            default: ;
        endcase
    endfunction

    function automatic bit [3:0] frame_class(int len, output int evk);
        int        base;
        bit [15:0] et;
        evk = -1;
        if (len < 14) return CLS_MALFORMED;
        base = 14;
        et = eth_outer;
        if (et == ETH_TYPE_VLAN)
        begin
            if (len < 18) return CLS_MALFORMED;
            et = eth_inner;
            base = 18;
        end
        if (et != ETH_TYPE_IPV4) return CLS_NONIP;
        if (len < base + 20) return CLS_MALFORMED;
        if (ihl_words < IHL_MIN) return CLS_MALFORMED;
        if (proto_num == IP_PROTO_UDP) return CLS_UDP;
        if (proto_num != IP_PROTO_TCP) return CLS_OTHERIP;
        if (len < base + 4 * int'(ihl_words) + 20) return CLS_MALFORMED;
        if (seg_flags[TCP_RST])
        begin
            evk = int'(EVT_KIND_RST);
            return CLS_RST;
        end
        if (seg_flags[TCP_SYN] && seg_flags[TCP_ACK]) return CLS_SYNACK;
        if (seg_flags[TCP_SYN]) return CLS_SYN;
        if (seg_flags[TCP_FIN]) return CLS_FIN;
        if (seg_flags[TCP_ACK]) return CLS_ACK;
        evk = int'(EVT_KIND_ODD);
        return CLS_ODDFLAGS;
    endfunction

    function automatic bit take_byte(trc_in_t it, output trc_out_t res);
        int       idx;
        int       len;
        int       evk;
        int       slot;
        bit [3:0] cls;
        res = '0;
        idx = it.first_byte ? 0 : int'(fr_offset);
        if (idx < MAX_FRAME_BYTES_DEF) grab_byte(idx, it.data_byte);
        len = (idx + 1 > MAX_FRAME_BYTES_DEF) ? MAX_FRAME_BYTES_DEF : idx + 1;
        if (!it.last_byte)
        begin
            fr_offset = 14'(len);
            return 1'b0;
        end
        fr_offset = '0;
        pkt_total = sat_add(pkt_total, 64'd1);
        byte_sum = sat_add(byte_sum, 64'(len));
        cls = frame_class(len, evk);
        res.pkt_class = cls;
        res.total_packets = pkt_total;
        res.total_bytes = byte_sum;
        if (cls != CLS_MALFORMED && cls != CLS_OTHERIP)
        begin
            slot = (cls < CLS_OTHERIP) ? int'(cls) - 1 : int'(cls) - 2;
            class_tally[slot] = sat_add(class_tally[slot], 64'd1);
            res.class_count = class_tally[slot];
        end
        if (evk >= 0)
        begin
            if (it.timestamp_ns - last_evt_ts[evk] >= {24'd0, cfg_interval})
            begin
                last_evt_ts[evk] = it.timestamp_ns;
                res.event_valid = 1'b1;
                res.event_kind = evk[0];
                res.event_time = it.timestamp_ns;
                res.event_src_addr = ip_src;
                res.event_dst_addr = ip_dst;
                res.event_src_port = tcp_sport;
                res.event_dst_port = tcp_dport;
                res.event_port = cfg_port;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit [7:0] tcp_bits(bit rst, bit syn, bit fin, bit ack);
        bit [7:0] f;
        f = '0;
        f[TCP_RST] = rst;
        f[TCP_SYN] = syn;
        f[TCP_FIN] = fin;
        f[TCP_ACK] = ack;
        return f;
    endfunction

    function automatic frame_row_t mk_row(bit vlan, bit [15:0] etype, bit [3:0] ihl,
                                          bit [7:0] proto, bit [7:0] flags, int len,
                                          bit [63:0] ts_step, bit typed, bit [3:0] cls);
        frame_row_t r;
        r.vlan = vlan;
        r.etype = etype;
        r.ihl = ihl;
        r.proto = proto;
        r.flags = flags;
        r.len = len;
        r.abort = 1'b0;
        r.nofirst = 1'b0;
        r.ts_step = ts_step;
        r.typed = typed;
        r.cls = cls;
        return r;
    endfunction

    function automatic frame_row_t random_frame();
        frame_row_t r;
        int         pick;
        int         need;
        r = mk_row($urandom_range(0, 3) == 0, ETH_TYPE_IPV4, IHL_MIN, IP_PROTO_TCP,
                   '0, 0, '0, 1'b0, CLS_MALFORMED);
        if ($urandom_range(0, 4) == 0) r.ihl = 4'($urandom_range(6, 15));
        case ($urandom_range(0, 9))
            0:       r.flags = tcp_bits(0, 1, 0, 0);
            1:       r.flags = tcp_bits(0, 1, 0, 1);
            2:       r.flags = tcp_bits(0, 0, 0, 1);
            3:       r.flags = tcp_bits(0, 0, 1, 1);
            4:       r.flags = tcp_bits(0, 0, 1, 0);
            5:       r.flags = tcp_bits(1, 0, 0, 0);
            6:       r.flags = tcp_bits(1, 0, 0, 1);
            7:       r.flags = tcp_bits(0, 0, 0, 0);
            default: r.flags = 8'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 12) r.proto = ($urandom_range(0, 1) != 0) ? IP_PROTO_UDP : 8'($urandom);
        else if (pick < 20) r.etype = 16'($urandom);
        else if (pick < 24) r.ihl = 4'($urandom_range(0, 4));
        need = (r.vlan ? 18 : 14) + 4 * int'(r.ihl) + 20;
        r.len = need + $urandom_range(0, 16);
        if (pick >= 24 && pick < 32) r.len = $urandom_range(1, need);
        if (pick >= 92)
        begin
            r.len = $urandom_range(1, 40);
            r.etype = 16'($urandom);
            r.abort = ($urandom_range(0, 1) != 0);
            r.nofirst = ($urandom_range(0, 3) == 0);
        end
        case ($urandom_range(0, 3))
            0:       r.ts_step = 64'($urandom_range(0, 1000));
            1:       r.ts_step = 64'($urandom_range(0, 400_000_000));
            2:       r.ts_step = {16'd0, 16'($urandom), 32'($urandom)};
            default: r.ts_step = {32'($urandom), 32'($urandom)};
        endcase
        return r;
    endfunction

    task automatic send_byte(trc_in_t it);
        int gap;
        gap = 0;
        if (!calm && tx_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= it;
        do @(posedge clk); while (!byte_ready);
    endtask

    task automatic send_frame(frame_row_t r);
        logic [7:0] fbytes [];
        trc_in_t    it;
        trc_out_t   res;
        int         base;
        int         hdr;
        fbytes = new[r.len + 128];
        foreach (fbytes[i]) fbytes[i] = 8'($urandom);
        base = r.vlan ? 18 : 14;
        hdr = base + 4 * int'(r.ihl);
        {fbytes[12], fbytes[13]} = r.vlan ? ETH_TYPE_VLAN : r.etype;
        if (r.vlan) {fbytes[16], fbytes[17]} = r.etype;
        fbytes[base][3:0] = r.ihl;
        fbytes[base + 9] = r.proto;
        fbytes[hdr + 13] = r.flags;
        tx_idle = ($urandom_range(0, 3) != 0);
        clock_ns += r.ts_step;
        frames_sent++;
        for (int i = 0; i < r.len; i++)
        begin
            it.data_byte = fbytes[i];
            it.first_byte = (i == 0) && !r.nofirst;
            it.last_byte = (i == r.len - 1) && !r.abort;
            it.timestamp_ns = it.last_byte ? clock_ns : {32'($urandom), 32'($urandom)};
            send_byte(it);
            bytes_sent++;
            if (take_byte(it, res))
            begin
                if (r.typed) res.pkt_class = r.cls;
                if (res.event_valid) events_due++;
                results_made++;
                results_due.push_back(res);
            end
        end
    endtask

    task automatic reg_write(logic [3:0] addr, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(bit [39:0] interval, bit [15:0] port);
        reg_write({REG_EVENT_INTERVAL, 3'b000}, {24'd0, interval});
        reg_write({REG_PORT_NUMBER, 3'b000}, {48'd0, port});
        cfg_interval = interval;
        cfg_port = port;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        trc_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result, class expected none got %0d",
                         $time, result_item.pkt_class);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("pkt_class", want.pkt_class, result_item.pkt_class);
                check_field("class_count", want.class_count, result_item.class_count);
                check_field("total_packets", want.total_packets, result_item.total_packets);
                check_field("total_bytes", want.total_bytes, result_item.total_bytes);
                check_field("event_valid", want.event_valid, result_item.event_valid);
                check_field("event_kind", want.event_kind, result_item.event_kind);
                check_field("event_time", want.event_time, result_item.event_time);
                check_field("event_src_addr", want.event_src_addr, result_item.event_src_addr);
                check_field("event_dst_addr", want.event_dst_addr, result_item.event_dst_addr);
                check_field("event_src_port", want.event_src_port, result_item.event_src_port);
                check_field("event_dst_port", want.event_dst_port, result_item.event_dst_port);
                check_field("event_port", want.event_port, result_item.event_port);
            end
        end
        if (calm) rx_hold = 0;
        else if (rx_hold != 0) rx_hold--;
        else if ($urandom_range(0, 11) == 0) rx_hold = $urandom_range(1, 16);
        result_ready <= (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (result_valid && result_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        frame_row_t directed_rows [$];
        frame_row_t r;
        int         start_bytes;

        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       1, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       13, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, 16'hFFFF, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       14, 10, 1, CLS_NONIP));
        directed_rows.push_back(mk_row(1, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       17, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(1, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       37, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       33, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 4, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       60, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_UDP, 8'h00,
                                       34, 10, 1, CLS_UDP));
        directed_rows.push_back(mk_row(1, ETH_TYPE_IPV4, 15, 8'hFF, 8'h00,
                                       60, 10, 1, CLS_OTHERIP));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       53, 10, 1, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(1, 0, 0, 0),
                                       54, EVT_INTERVAL_RST, 1, CLS_RST));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, 8'hFF,
                                       54, EVT_INTERVAL_RST, 1, CLS_RST));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(1, 0, 0, 0),
                                       54, EVT_INTERVAL_RST - 1, 1, CLS_RST));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 1, 0, 1),
                                       60, 10, 0, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 1, 0, 0),
                                       54, 10, 0, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 1, 0),
                                       54, 10, 0, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                                       64, 10, 0, CLS_MALFORMED));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, 8'h00,
                                       54, 10, 1, CLS_ODDFLAGS));
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, 8'h08,
                                       54, 10, 1, CLS_ODDFLAGS));
        directed_rows.push_back(mk_row(1, ETH_TYPE_IPV4, 15, IP_PROTO_TCP, tcp_bits(0, 0, 1, 1),
                                       103, 10, 1, CLS_FIN));
        r = mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 0, 0, 1),
                   30, 10, 0, CLS_MALFORMED);
        r.abort = 1'b1;
        directed_rows.push_back(r);
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_UDP, 8'h00,
                                       40, 10, 1, CLS_UDP));
        r = mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(0, 1, 0, 0),
                   54, 10, 1, CLS_SYN);
        r.nofirst = 1'b1;
        directed_rows.push_back(r);
        directed_rows.push_back(mk_row(0, ETH_TYPE_IPV4, 5, IP_PROTO_TCP, tcp_bits(1, 0, 0, 0),
                                       54, 64'hFFFF_FFFF_FFFF_0000, 0, CLS_MALFORMED));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) send_frame(directed_rows[i]);

        for (int p = 0; p < 4; p++)
        begin
            if (p != 0)
            begin
                drain();
                case (p)
                    1:       apply_config(40'd0, 16'hFFFF);
                    2:       apply_config('1, 16'($urandom));
                    default: apply_config(40'($urandom_range(1, 50_000_000)), 16'd0);
                endcase
            end
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < RANDOM_BYTES / 4)
            begin
                calm = (p == 3) && (bytes_sent - start_bytes >= RANDOM_BYTES / 4 - CALM_BYTES);
                send_frame(random_frame());
            end
        end

        drain();
        $display("Sent %0d frames (%0d bytes) under the reset and three written register settings",
                 frames_sent, bytes_sent);
        $display("Checked %0d classifications, %0d of them carrying a rate-limited event",
                 results_seen, events_due);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: tcp_reply_classifier_top.f
hw/rtl/trc_pkg.sv
hw/rtl/trc_parser.sv
hw/rtl/trc_classifier.sv
hw/rtl/trc_result_fifo.sv
hw/rtl/tcp_reply_classifier_top.sv
tb/tcp_reply_classifier_top_tb.sv
